FILE: rtl/xxh_pkg.sv
// Shared types, constants and helpers for the XXH64 stream hash block.
package xxh_pkg;

    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;
    localparam logic [63:0] SEED_RESET = 64'h4153504952415041;
    localparam logic [3:0]  FULL_BYTES = 4'd8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_PEND_WR,
        OP_STRIPE_DONE,
        OP_TOTAL_ADD,
        OP_MUL_LOAD,
        OP_MUL_P0,
        OP_MUL_P1,
        OP_MUL_P2,
        OP_H_LOAD,
        OP_H_ADD,
        OP_H_XOR,
        OP_LANE_WR,
        OP_FINISH
    } op_t;

    typedef enum logic [4:0] {
        SRC_LANE,
        SRC_LANE_ROT,
        SRC_PEND,
        SRC_WORD,
        SRC_WORD32,
        SRC_BYTE,
        SRC_H,
        SRC_H_ROT27,
        SRC_H_ROT23,
        SRC_H_ROT11,
        SRC_H_X33,
        SRC_SEED_P5,
        SRC_TOTAL,
        SRC_PROD,
        SRC_PROD_P4,
        SRC_PROD_P3,
        SRC_PROD_X29,
        SRC_PROD_X32,
        SRC_MIXL,
        SRC_MIX0
    } src_t;

    typedef enum logic [1:0] {
        K_P1,
        K_P2,
        K_P3,
        K_P5
    } konst_t;

    typedef struct packed {
        op_t        op;
        src_t       src;
        konst_t     k;
        logic [2:0] sel;
    } cmd_t;

    typedef struct packed {
        logic       last;
        logic       seen;
        logic [1:0] pcount;
        logic [3:0] count;
    } status_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] dbl;
        begin
            dbl = {x, x} << r;
            rotl64 = dbl[127:64];
        end
    endfunction

endpackage

FILE: rtl/xxh_if.sv
// Request channel interfaces: message words, digests and seed writes.
interface xxh_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
    modport source (output valid, data_word, byte_count, last_word, input ready);
    modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xxh_digest_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;
    modport source (output valid, digest, input ready);
    modport sink (input valid, digest, output ready);
endinterface

interface xxh_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_seed;
    modport source (output valid, hash_seed, input ready);
    modport sink (input valid, hash_seed, output ready);
endinterface

FILE: rtl/xxh_dpath.sv
// Datapath: message state, lane accumulators, hash register and shared multiplier.
module xxh_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  xxh_pkg::cmd_t   cmd,
    output xxh_pkg::status_t status,
    input  logic [63:0]     data_word,
    input  logic [3:0]      byte_count,
    input  logic            last_word,
    input  logic            cfg_valid,
    input  logic [63:0]     cfg_seed,
    output logic [63:0]     digest
);

    logic [63:0] seed_reg;
    logic [63:0] lane_reg [4];
    logic [63:0] pend_reg [3];
    logic [1:0]  pcount_reg;
    logic        seen_reg;
    logic [63:0] total_reg;
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        last_reg;
    logic [63:0] h_reg;
    logic [63:0] mul_a_reg;
    logic [63:0] mul_b_reg;
    logic [63:0] prod_reg;
    logic [63:0] digest_reg;

    logic [63:0] src_val;
    logic [63:0] k_val;
    logic [63:0] lane_sel;
    logic [63:0] pend_sel;
    logic [5:0]  lane_rot;
    logic [31:0] m_x;
    logic [31:0] m_y;
    logic [63:0] m_p;
    logic [63:0] prod_next;
    logic [3:0]  count_next;
    logic        msg_empty;

    assign status.last   = last_reg;
    assign status.seen   = seen_reg;
    assign status.pcount = pcount_reg;
    assign status.count  = count_reg;
    assign digest        = digest_reg;

    assign msg_empty = (total_reg == 64'd0) && (pcount_reg == 2'd0) && !seen_reg;

    always_comb
    begin
        lane_sel = lane_reg[cmd.sel[1:0]];
        unique case (cmd.sel[1:0])
            2'd0:    lane_rot = 6'd1;
            2'd1:    lane_rot = 6'd7;
            2'd2:    lane_rot = 6'd12;
            default: lane_rot = 6'd18;
        endcase
        unique case (cmd.sel[1:0])
            2'd0:    pend_sel = pend_reg[0];
            2'd1:    pend_sel = pend_reg[1];
            2'd2:    pend_sel = pend_reg[2];
            default: pend_sel = 64'd0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.src)
            xxh_pkg::SRC_LANE:     src_val = lane_sel;
            xxh_pkg::SRC_LANE_ROT: src_val = xxh_pkg::rotl64(lane_sel, lane_rot);
            xxh_pkg::SRC_PEND:     src_val = pend_sel;
            xxh_pkg::SRC_WORD:     src_val = word_reg;
            xxh_pkg::SRC_WORD32:   src_val = {32'd0, word_reg[31:0]};
            xxh_pkg::SRC_BYTE:     src_val = {56'd0, word_reg[cmd.sel*8 +: 8]};
            xxh_pkg::SRC_H:        src_val = h_reg;
            xxh_pkg::SRC_H_ROT27:  src_val = xxh_pkg::rotl64(h_reg, 6'd27);
            xxh_pkg::SRC_H_ROT23:  src_val = xxh_pkg::rotl64(h_reg, 6'd23);
            xxh_pkg::SRC_H_ROT11:  src_val = xxh_pkg::rotl64(h_reg, 6'd11);
            xxh_pkg::SRC_H_X33:    src_val = h_reg ^ (h_reg >> 33);
            xxh_pkg::SRC_SEED_P5:  src_val = seed_reg + xxh_pkg::P5;
            xxh_pkg::SRC_TOTAL:    src_val = total_reg;
            xxh_pkg::SRC_PROD:     src_val = prod_reg;
            xxh_pkg::SRC_PROD_P4:  src_val = prod_reg + xxh_pkg::P4;
            xxh_pkg::SRC_PROD_P3:  src_val = prod_reg + xxh_pkg::P3;
            xxh_pkg::SRC_PROD_X29: src_val = prod_reg ^ (prod_reg >> 29);
            xxh_pkg::SRC_PROD_X32: src_val = prod_reg ^ (prod_reg >> 32);
            xxh_pkg::SRC_MIXL:     src_val = xxh_pkg::rotl64(lane_sel + prod_reg, 6'd31);
            xxh_pkg::SRC_MIX0:     src_val = xxh_pkg::rotl64(prod_reg, 6'd31);
            default:               src_val = 64'd0;
        endcase
        unique case (cmd.k)
            xxh_pkg::K_P1: k_val = xxh_pkg::P1;
            xxh_pkg::K_P2: k_val = xxh_pkg::P2;
            xxh_pkg::K_P3: k_val = xxh_pkg::P3;
            default:       k_val = xxh_pkg::P5;
        endcase
    end

    // 64x64 low product accumulated from three 32x32 partial products
    always_comb
    begin
        unique case (cmd.op)
            xxh_pkg::OP_MUL_P1:
            begin
                m_x = mul_a_reg[31:0];
                m_y = mul_b_reg[63:32];
            end
            xxh_pkg::OP_MUL_P2:
            begin
                m_x = mul_a_reg[63:32];
                m_y = mul_b_reg[31:0];
            end
            default:
            begin
                m_x = mul_a_reg[31:0];
                m_y = mul_b_reg[31:0];
            end
        endcase
        m_p = 64'(m_x) * 64'(m_y);
        if (cmd.op == xxh_pkg::OP_MUL_P0)
            prod_next = m_p;
        else
            prod_next = prod_reg + {m_p[31:0], 32'd0};
    end

    // a non-last word always counts as full; oversized counts saturate
    assign count_next = !last_word ? xxh_pkg::FULL_BYTES :
                        (byte_count > xxh_pkg::FULL_BYTES) ? xxh_pkg::FULL_BYTES : byte_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= xxh_pkg::SEED_RESET;
            lane_reg[0] <= xxh_pkg::SEED_RESET + xxh_pkg::P1 + xxh_pkg::P2;
            lane_reg[1] <= xxh_pkg::SEED_RESET + xxh_pkg::P2;
            lane_reg[2] <= xxh_pkg::SEED_RESET;
            lane_reg[3] <= xxh_pkg::SEED_RESET - xxh_pkg::P1;
            pcount_reg  <= 2'd0;
            seen_reg    <= 1'b0;
            total_reg   <= 64'd0;
            last_reg    <= 1'b0;
            count_reg   <= 4'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= cfg_seed;
                if (msg_empty)
                begin
                    lane_reg[0] <= cfg_seed + xxh_pkg::P1 + xxh_pkg::P2;
                    lane_reg[1] <= cfg_seed + xxh_pkg::P2;
                    lane_reg[2] <= cfg_seed;
                    lane_reg[3] <= cfg_seed - xxh_pkg::P1;
                end
            end
            unique case (cmd.op)
                xxh_pkg::OP_CAPTURE:
                begin
                    last_reg  <= last_word;
                    count_reg <= count_next;
                end
                xxh_pkg::OP_PEND_WR:
                begin
                    pcount_reg <= pcount_reg + 2'd1;
                    total_reg  <= total_reg + 64'd8;
                end
                xxh_pkg::OP_STRIPE_DONE:
                begin
                    pcount_reg <= 2'd0;
                    seen_reg   <= 1'b1;
                    total_reg  <= total_reg + 64'd8;
                    if (last_reg)
                        count_reg <= 4'd0;
                end
                xxh_pkg::OP_TOTAL_ADD: total_reg <= total_reg + 64'(count_reg);
                xxh_pkg::OP_LANE_WR:   lane_reg[cmd.sel[1:0]] <= prod_reg;
                xxh_pkg::OP_FINISH:
                begin
                    lane_reg[0] <= seed_reg + xxh_pkg::P1 + xxh_pkg::P2;
                    lane_reg[1] <= seed_reg + xxh_pkg::P2;
                    lane_reg[2] <= seed_reg;
                    lane_reg[3] <= seed_reg - xxh_pkg::P1;
                    pcount_reg  <= 2'd0;
                    seen_reg    <= 1'b0;
                    total_reg   <= 64'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            xxh_pkg::OP_CAPTURE:  word_reg <= data_word;
            xxh_pkg::OP_PEND_WR:
            begin
                unique case (pcount_reg)
                    2'd0:    pend_reg[0] <= word_reg;
                    2'd1:    pend_reg[1] <= word_reg;
                    default: pend_reg[2] <= word_reg;
                endcase
            end
            xxh_pkg::OP_MUL_LOAD:
            begin
                mul_a_reg <= src_val;
                mul_b_reg <= k_val;
            end
            xxh_pkg::OP_MUL_P0, xxh_pkg::OP_MUL_P1, xxh_pkg::OP_MUL_P2: prod_reg <= prod_next;
            xxh_pkg::OP_H_LOAD:   h_reg <= src_val;
            xxh_pkg::OP_H_ADD:    h_reg <= h_reg + src_val;
            xxh_pkg::OP_H_XOR:    h_reg <= h_reg ^ src_val;
            xxh_pkg::OP_FINISH:   digest_reg <= h_reg;
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/xxh_ctrl.sv
// Controller: sequences stripe rounds, tail folding and avalanche on the datapath.
module xxh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  xxh_pkg::status_t status,
    output xxh_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_MP0, S_MP1, S_MP2,
        S_LN_A, S_LN_B, S_LN_C, S_STRIPE_DONE,
        S_FIN_START, S_CONV,
        S_MRG_A, S_MRG_B, S_MRG_C, S_MRG_D, S_MRG_E,
        S_TOT, S_PEND_CHK,
        S_FW_A, S_FW_B, S_FW_C, S_FW_D, S_FW_E,
        S_W4_A, S_W4_B, S_W4_C, S_W4_D,
        S_BY_CHK, S_BY_B, S_BY_C, S_BY_D,
        S_AV_A, S_AV_B, S_AV_C, S_AV_D, S_AV_E, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [1:0]  idx_reg, idx_next;
    logic [3:0]  pos_reg, pos_next;
    logic        fw_word_reg, fw_word_next;
    logic        out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        fw_word_next   = fw_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op  = xxh_pkg::OP_NOP;
        cmd.src = xxh_pkg::SRC_H;
        cmd.k   = xxh_pkg::K_P1;
        cmd.sel = {1'b0, idx_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = xxh_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                idx_next = 2'd0;
                if (status.pcount == 2'd3 &&
                    (!status.last || status.count == xxh_pkg::FULL_BYTES))
                    state_next = S_LN_A;
                else if (!status.last)
                begin
                    cmd.op     = xxh_pkg::OP_PEND_WR;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = xxh_pkg::OP_TOTAL_ADD;
                    state_next = S_FIN_START;
                end
            end
            S_MP0:
            begin
                cmd.op     = xxh_pkg::OP_MUL_P0;
                state_next = S_MP1;
            end
            S_MP1:
            begin
                cmd.op     = xxh_pkg::OP_MUL_P1;
                state_next = S_MP2;
            end
            S_MP2:
            begin
                cmd.op     = xxh_pkg::OP_MUL_P2;
                state_next = ret_reg;
            end
            // stripe: lane = rotl(lane + w*P2, 31) * P1
            S_LN_A:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = (idx_reg == 2'd3) ? xxh_pkg::SRC_WORD : xxh_pkg::SRC_PEND;
                cmd.k      = xxh_pkg::K_P2;
                ret_next   = S_LN_B;
                state_next = S_MP0;
            end
            S_LN_B:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_MIXL;
                cmd.k      = xxh_pkg::K_P1;
                ret_next   = S_LN_C;
                state_next = S_MP0;
            end
            S_LN_C:
            begin
                cmd.op   = xxh_pkg::OP_LANE_WR;
                idx_next = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? S_STRIPE_DONE : S_LN_A;
            end
            S_STRIPE_DONE:
            begin
                cmd.op     = xxh_pkg::OP_STRIPE_DONE;
                state_next = status.last ? S_FIN_START : S_IDLE;
            end
            S_FIN_START:
            begin
                cmd.op = xxh_pkg::OP_H_LOAD;
                cmd.sel = 3'd0;
                if (status.seen)
                begin
                    cmd.src    = xxh_pkg::SRC_LANE_ROT;
                    idx_next   = 2'd1;
                    state_next = S_CONV;
                end
                else
                begin
                    cmd.src    = xxh_pkg::SRC_SEED_P5;
                    state_next = S_TOT;
                end
            end
            S_CONV:
            begin
                cmd.op   = xxh_pkg::OP_H_ADD;
                cmd.src  = xxh_pkg::SRC_LANE_ROT;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    state_next = S_MRG_A;
            end
            S_MRG_A:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_LANE;
                cmd.k      = xxh_pkg::K_P2;
                ret_next   = S_MRG_B;
                state_next = S_MP0;
            end
            S_MRG_B:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_MIX0;
                cmd.k      = xxh_pkg::K_P1;
                ret_next   = S_MRG_C;
                state_next = S_MP0;
            end
            S_MRG_C:
            begin
                cmd.op     = xxh_pkg::OP_H_XOR;
                cmd.src    = xxh_pkg::SRC_PROD;
                state_next = S_MRG_D;
            end
            S_MRG_D:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_H;
                cmd.k      = xxh_pkg::K_P1;
                ret_next   = S_MRG_E;
                state_next = S_MP0;
            end
            S_MRG_E:
            begin
                cmd.op     = xxh_pkg::OP_H_LOAD;
                cmd.src    = xxh_pkg::SRC_PROD_P4;
                idx_next   = idx_reg + 2'd1;
                state_next = (idx_reg == 2'd3) ? S_TOT : S_MRG_A;
            end
            S_TOT:
            begin
                cmd.op     = xxh_pkg::OP_H_ADD;
                cmd.src    = xxh_pkg::SRC_TOTAL;
                idx_next   = 2'd0;
                state_next = S_PEND_CHK;
            end
            S_PEND_CHK:
            begin
                fw_word_next = 1'b0;
                pos_next     = 4'd0;
                priority if (idx_reg < status.pcount)
                    state_next = S_FW_A;
                else if (status.count == xxh_pkg::FULL_BYTES)
                begin
                    fw_word_next = 1'b1;
                    state_next   = S_FW_A;
                end
                else if (status.count >= 4'd4)
                    state_next = S_W4_A;
                else
                    state_next = S_BY_CHK;
            end
            // fold: h ^= mix(0, w); h = rotl(h, 27) * P1 + P4
            S_FW_A:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = fw_word_reg ? xxh_pkg::SRC_WORD : xxh_pkg::SRC_PEND;
                cmd.k      = xxh_pkg::K_P2;
                ret_next   = S_FW_B;
                state_next = S_MP0;
            end
            S_FW_B:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_MIX0;
                cmd.k      = xxh_pkg::K_P1;
                ret_next   = S_FW_C;
                state_next = S_MP0;
            end
            S_FW_C:
            begin
                cmd.op     = xxh_pkg::OP_H_XOR;
                cmd.src    = xxh_pkg::SRC_PROD;
                state_next = S_FW_D;
            end
            S_FW_D:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_H_ROT27;
                cmd.k      = xxh_pkg::K_P1;
                ret_next   = S_FW_E;
                state_next = S_MP0;
            end
            S_FW_E:
            begin
                cmd.op  = xxh_pkg::OP_H_LOAD;
                cmd.src = xxh_pkg::SRC_PROD_P4;
                if (fw_word_reg)
                    state_next = S_AV_A;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = S_PEND_CHK;
                end
            end
            S_W4_A:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_WORD32;
                cmd.k      = xxh_pkg::K_P1;
                ret_next   = S_W4_B;
                state_next = S_MP0;
            end
            S_W4_B:
            begin
                cmd.op     = xxh_pkg::OP_H_XOR;
                cmd.src    = xxh_pkg::SRC_PROD;
                state_next = S_W4_C;
            end
            S_W4_C:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_H_ROT23;
                cmd.k      = xxh_pkg::K_P2;
                ret_next   = S_W4_D;
                state_next = S_MP0;
            end
            S_W4_D:
            begin
                cmd.op     = xxh_pkg::OP_H_LOAD;
                cmd.src    = xxh_pkg::SRC_PROD_P3;
                pos_next   = 4'd4;
                state_next = S_BY_CHK;
            end
            S_BY_CHK:
            begin
                if (pos_reg < status.count)
                begin
                    cmd.op     = xxh_pkg::OP_MUL_LOAD;
                    cmd.src    = xxh_pkg::SRC_BYTE;
                    cmd.k      = xxh_pkg::K_P5;
                    cmd.sel    = pos_reg[2:0];
                    ret_next   = S_BY_B;
                    state_next = S_MP0;
                end
                else
                    state_next = S_AV_A;
            end
            S_BY_B:
            begin
                cmd.op     = xxh_pkg::OP_H_XOR;
                cmd.src    = xxh_pkg::SRC_PROD;
                state_next = S_BY_C;
            end
            S_BY_C:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_H_ROT11;
                cmd.k      = xxh_pkg::K_P1;
                ret_next   = S_BY_D;
                state_next = S_MP0;
            end
            S_BY_D:
            begin
                cmd.op     = xxh_pkg::OP_H_LOAD;
                cmd.src    = xxh_pkg::SRC_PROD;
                pos_next   = pos_reg + 4'd1;
                state_next = S_BY_CHK;
            end
            S_AV_A:
            begin
                cmd.op     = xxh_pkg::OP_H_LOAD;
                cmd.src    = xxh_pkg::SRC_H_X33;
                state_next = S_AV_B;
            end
            S_AV_B:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_H;
                cmd.k      = xxh_pkg::K_P2;
                ret_next   = S_AV_C;
                state_next = S_MP0;
            end
            S_AV_C:
            begin
                cmd.op     = xxh_pkg::OP_H_LOAD;
                cmd.src    = xxh_pkg::SRC_PROD_X29;
                state_next = S_AV_D;
            end
            S_AV_D:
            begin
                cmd.op     = xxh_pkg::OP_MUL_LOAD;
                cmd.src    = xxh_pkg::SRC_H;
                cmd.k      = xxh_pkg::K_P3;
                ret_next   = S_AV_E;
                state_next = S_MP0;
            end
            S_AV_E:
            begin
                cmd.op     = xxh_pkg::OP_H_LOAD;
                cmd.src    = xxh_pkg::SRC_PROD_X32;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = xxh_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            idx_reg       <= 2'd0;
            pos_reg       <= 4'd0;
            fw_word_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            fw_word_reg   <= fw_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DISPATCH)
        else $error("accepted request not dispatched");

    a_mul_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MP0 |-> $past(cmd.op) == xxh_pkg::OP_MUL_LOAD)
        else $error("multiply started without operand load");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == xxh_pkg::OP_FINISH |-> !out_valid_reg || out_ready)
        else $error("digest overwritten while pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("digest dropped before taken");
`endif

endmodule

FILE: rtl/xxh64_stream_hash_top.sv
// Top level of the streaming XXH64 hash block.
//
// Channels: msg carries message words (data_word little-endian, byte_count,
// last_word); hash returns one 64-bit digest per message; cfg writes hash_seed.
// cfg is always ready; write it only between messages to reseed the lanes.
// Throughput is set by one shared 32x32 multiplier; each 64-bit product takes
// an operand load plus three partial products.
// A word that is only queued passes through capture and dispatch. A word
// completing a 32-byte stripe runs four lane rounds of two products each.
// After dispatch, the last word runs the tail: lane convergence plus a merge
// per lane when a stripe was seen, adding the length, a fold per queued or
// full final word, a 4-byte step, a fold per leftover byte, checks between
// the steps, then avalanche and a final step that loads the output register.
// The digest lands in an output register; the next message is accepted while
// it waits. A stalled receiver blocks only the next digest write.
// Reset clears the message state and loads the default seed.
module xxh64_stream_hash_top (
    input logic              clk,
    input logic              rst_n,
    xxh_msg_if.sink          msg,
    xxh_digest_if.source     hash,
    xxh_cfg_if.sink          cfg
);

    xxh_pkg::cmd_t    cmd;
    xxh_pkg::status_t status;

    assign cfg.ready = 1'b1;

    xxh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .in_ready  (msg.ready),
        .out_valid (hash.valid),
        .out_ready (hash.ready),
        .status    (status),
        .cmd       (cmd)
    );

    xxh_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .data_word  (msg.data_word),
        .byte_count (msg.byte_count),
        .last_word  (msg.last_word),
        .cfg_valid  (cfg.valid),
        .cfg_seed   (cfg.hash_seed),
        .digest     (hash.digest)
    );

endmodule
